>>> hdl/obfd_pkg.sv
// Package for the sync-word block deframer.
// Holds the link word codes, parse phase codes, result kind codes and window limits.
// No dependencies.
package obfd_pkg;

  // Link words
  localparam logic [15:0] SYNC_NORMAL = 16'haa55;
  localparam logic [15:0] SYNC_CC     = 16'haa56;
  localparam logic [15:0] SYNC_SLIP   = 16'h55aa;
  localparam logic [15:0] NO_WORD     = 16'hffff;

  // Parse phases
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_CSUM   = 2'd1;
  localparam logic [1:0] PH_FIELDS = 2'd2;
  localparam logic [1:0] PH_AFTER  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BLOCK   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_NOFRAME = 2'd2;

  // Window limits
  localparam logic [20:0] HORIZON_Y  = 21'd110;
  localparam logic [20:0] TRAP_LOW   = 21'd810;
  localparam logic [20:0] TRAP_HIGH  = 21'd2340;
  localparam logic [20:0] CLAW_X_MIN = 21'd100;
  localparam logic [20:0] CLAW_X_MAX = 21'd250;

  // Window selection
  localparam logic WIN_UPPER_TRAP = 1'b0;

endpackage

>>> hdl/obfd_window.sv
// Target window test for one block centre.
// Exact integer form of the upper trapezoid and the claw rectangle.
// Depends on obfd_pkg.
module obfd_window (
  input  logic        mode,
  input  logic [15:0] x,
  input  logic [15:0] y,
  output logic        hit
);
  import obfd_pkg::*;

  logic [20:0] x_w;
  logic [20:0] y_w;
  logic [20:0] x9;
  logic [20:0] y2;
  logic        trap_hit;
  logic        claw_hit;

  // Widen and scale the coordinates
  assign x_w = {5'd0, x};
  assign y_w = {5'd0, y};
  assign x9  = (x_w << 3) + x_w;
  assign y2  = y_w << 1;

  // Upper trapezoid: y < 110, 9x + 2y > 810, 9x < 2340 + 2y
  assign trap_hit = (y_w < HORIZON_Y) && ((x9 + y2) > TRAP_LOW) && (x9 < (TRAP_HIGH + y2));

  // Claw rectangle: y > 110, 100 < x < 250
  assign claw_hit = (y_w > HORIZON_Y) && (x_w > CLAW_X_MIN) && (x_w < CLAW_X_MAX);

  assign hit = (mode == WIN_UPPER_TRAP) ? trap_hit : claw_hit;

endmodule

>>> hdl/object_block_frame_deframer.sv
// Top level of the sync-word block deframer.
// Pairs bytes into words, parses block records and frame summaries.
// Depends on obfd_pkg and obfd_window.

// Takes one received byte per cycle and answers with at most one result per
// byte: the byte lands in an input register, word assembly and record parsing
// run combinationally from that register, and the result is written to the
// output register at the edge that takes the byte. A byte is taken in every
// cycle unless a finished result is held by out_stall. Bytes pair
// little-endian into words; a doubled 0xaa55 (normal) or 0xaa56 (colour-code)
// opens a frame, and a 0x55aa while hunting drops one byte to fix the pairing.
// Each block record comes out with checksum_ok and color_code; the frame end
// gives block_count and the largest-area block inside the window chosen by
// window_mode (0 upper trapezoid, 1 claw rectangle); the user must write it
// through cfg_data only while the block is idle, and the block does not
// enforce this. A frame holds up to MAX_BLOCKS blocks.
module object_block_frame_deframer #(
  parameter int MAX_BLOCKS = 30
) (
  input  logic        clk,
  input  logic        rst,
  // Byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] signature,
  output logic [15:0] x_pos,
  output logic [15:0] y_pos,
  output logic [15:0] box_width,
  output logic [15:0] box_height,
  output logic [15:0] angle,
  output logic        checksum_ok,
  output logic        color_code,
  output logic [4:0]  block_count,
  output logic        best_found,
  output logic [4:0]  best_index
);
  import obfd_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_BLOCKS);

  // Configuration
  logic window_mode;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       take;

  // Parse state
  logic [1:0]    parse_phase, parse_phase_next;
  logic          byte_half, byte_half_next;
  logic [7:0]    low_byte_hold, low_byte_hold_next;
  logic [15:0]   previous_word, previous_word_next;
  logic [2:0]    field_counter, field_counter_next;
  logic [15:0]   block_fields [5];
  logic [15:0]   received_checksum, received_checksum_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [CW-1:0] frame_block_count, frame_block_count_next;
  logic          color_code_mode, color_code_mode_next;
  logic [31:0]   best_area, best_area_next;
  logic [CW-1:0] best_slot, best_slot_next;
  logic          best_valid, best_valid_next;
  logic          drop_next, drop_next_next;
  logic          fld_we;

  // Word and block datapath
  logic [15:0]   word;
  logic [15:0]   cur_height;
  logic [31:0]   area;
  logic          win_hit;
  logic [CW+4:0] count_wide;
  logic [CW+4:0] slot_wide;

  // Result before the output register
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [15:0] res_sig, res_x, res_y, res_w, res_h, res_ang;
  logic        res_ckok, res_cc, res_found;
  logic [4:0]  res_count, res_index;

  // Configuration port: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      window_mode <= cfg_data;
    end
  end

  // Handshake: advance when the output register is empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // Assemble the word and evaluate the finished block
  assign word       = {s1_byte, low_byte_hold};
  assign cur_height = (field_counter == 3'd4) ? word : block_fields[4];
  assign area       = {16'd0, block_fields[3]} * {16'd0, cur_height};

  obfd_window u_window (
    .mode (window_mode),
    .x    (block_fields[1]),
    .y    (block_fields[2]),
    .hit  (win_hit)
  );

  assign count_wide = {5'd0, frame_block_count};
  assign slot_wide  = {5'd0, best_slot};

  // Parse one byte
  always_comb begin
    parse_phase_next       = parse_phase;
    byte_half_next         = byte_half;
    low_byte_hold_next     = low_byte_hold;
    previous_word_next     = previous_word;
    field_counter_next     = field_counter;
    received_checksum_next = received_checksum;
    running_sum_next       = running_sum;
    frame_block_count_next = frame_block_count;
    color_code_mode_next   = color_code_mode;
    best_area_next         = best_area;
    best_slot_next         = best_slot;
    best_valid_next        = best_valid;
    drop_next_next         = drop_next;
    fld_we                 = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_BLOCK;
    res_sig   = 16'd0;
    res_x     = 16'd0;
    res_y     = 16'd0;
    res_w     = 16'd0;
    res_h     = 16'd0;
    res_ang   = 16'd0;
    res_ckok  = 1'b0;
    res_cc    = 1'b0;
    res_count = 5'd0;
    res_found = 1'b0;
    res_index = 5'd0;

    if (take) begin
      if (drop_next) begin
        // Drop one byte to realign the pairing
        drop_next_next = 1'b0;
      end else if (!byte_half) begin
        // Hold the low byte
        low_byte_hold_next = s1_byte;
        byte_half_next     = 1'b1;
      end else begin
        byte_half_next = 1'b0;
        case (parse_phase)
          PH_HUNT: begin
            if (word == 16'd0 && previous_word == 16'd0) begin
              frame_block_count_next = '0;
              previous_word_next     = NO_WORD;
              res_valid              = 1'b1;
              res_kind               = KIND_NOFRAME;
            end else if ((word == SYNC_NORMAL && previous_word == SYNC_NORMAL) ||
                         (word == SYNC_CC && previous_word == SYNC_CC)) begin
              color_code_mode_next   = (word == SYNC_CC);
              frame_block_count_next = '0;
              best_area_next         = 32'd0;
              best_slot_next         = '0;
              best_valid_next        = 1'b0;
              parse_phase_next       = PH_CSUM;
            end else begin
              if (word == SYNC_SLIP) begin
                drop_next_next = 1'b1;
              end
              previous_word_next = word;
            end
          end
          PH_CSUM: begin
            if (word == SYNC_NORMAL || word == SYNC_CC || word == 16'd0) begin
              // Close the frame
              res_valid = 1'b1;
              res_kind  = KIND_SUMMARY;
              res_count = count_wide[4:0];
              res_found = best_valid;
              res_index = best_valid ? slot_wide[4:0] : 5'd0;
              if (word == 16'd0) begin
                parse_phase_next   = PH_HUNT;
                previous_word_next = NO_WORD;
              end else begin
                // Open the next frame at once
                color_code_mode_next   = (word == SYNC_CC);
                frame_block_count_next = '0;
                best_area_next         = 32'd0;
                best_slot_next         = '0;
                best_valid_next        = 1'b0;
                parse_phase_next       = PH_CSUM;
              end
            end else begin
              received_checksum_next = word;
              running_sum_next       = 16'd0;
              field_counter_next     = 3'd0;
              parse_phase_next       = PH_FIELDS;
            end
          end
          PH_FIELDS: begin
            fld_we             = (field_counter < 3'd5);
            running_sum_next   = running_sum + word;
            field_counter_next = field_counter + 3'd1;
            if ((field_counter_next == 3'd5 && !color_code_mode) ||
                field_counter_next >= 3'd6) begin
              res_valid = 1'b1;
              res_kind  = KIND_BLOCK;
              res_sig   = block_fields[0];
              res_x     = block_fields[1];
              res_y     = block_fields[2];
              res_w     = block_fields[3];
              res_h     = cur_height;
              res_ang   = (field_counter >= 3'd5) ? word : 16'd0;
              res_ckok  = (running_sum_next == received_checksum);
              res_cc    = color_code_mode;
              // Track the largest in-window block
              if (win_hit && area > best_area) begin
                best_area_next  = area;
                best_slot_next  = frame_block_count;
                best_valid_next = 1'b1;
              end
              frame_block_count_next = frame_block_count + CW'(1);
              parse_phase_next       = PH_AFTER;
            end
          end
          default: begin
            if ((word == SYNC_NORMAL || word == SYNC_CC) && frame_block_count < CAP) begin
              color_code_mode_next = (word == SYNC_CC);
              parse_phase_next     = PH_CSUM;
            end else begin
              if (word == SYNC_NORMAL || word == SYNC_CC) begin
                color_code_mode_next = (word == SYNC_CC);
              end
              res_valid          = 1'b1;
              res_kind           = KIND_SUMMARY;
              res_count          = count_wide[4:0];
              res_found          = best_valid;
              res_index          = best_valid ? slot_wide[4:0] : 5'd0;
              parse_phase_next   = PH_HUNT;
              previous_word_next = NO_WORD;
            end
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HUNT;
      byte_half         <= 1'b0;
      low_byte_hold     <= 8'd0;
      previous_word     <= NO_WORD;
      field_counter     <= 3'd0;
      running_sum       <= 16'd0;
      frame_block_count <= '0;
      color_code_mode   <= 1'b0;
      best_area         <= 32'd0;
      best_slot         <= '0;
      best_valid        <= 1'b0;
      drop_next         <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      byte_half         <= byte_half_next;
      low_byte_hold     <= low_byte_hold_next;
      previous_word     <= previous_word_next;
      field_counter     <= field_counter_next;
      running_sum       <= running_sum_next;
      frame_block_count <= frame_block_count_next;
      color_code_mode   <= color_code_mode_next;
      best_area         <= best_area_next;
      best_slot         <= best_slot_next;
      best_valid        <= best_valid_next;
      drop_next         <= drop_next_next;
    end
  end

  // Record fields and checksum
  always_ff @(posedge clk) begin
    received_checksum <= received_checksum_next;
    if (fld_we) begin
      block_fields[field_counter] <= word;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      result_kind <= res_kind;
      signature   <= res_sig;
      x_pos       <= res_x;
      y_pos       <= res_y;
      box_width   <= res_w;
      box_height  <= res_h;
      angle       <= res_ang;
      checksum_ok <= res_ckok;
      color_code  <= res_cc;
      block_count <= res_count;
      best_found  <= res_found;
      best_index  <= res_index;
    end
  end

`ifndef SYNTHESIS
  // Block count never passes the frame cap
  assert property (@(posedge clk) disable iff (rst) frame_block_count <= CAP)
    else $error("frame block count above cap");

  // A byte drop is only pending on a word boundary
  assert property (@(posedge clk) disable iff (rst) !(drop_next && byte_half))
    else $error("byte drop pending in the middle of a word");

  // Inside a frame the best block is one already counted
  assert property (@(posedge clk) disable iff (rst)
    (best_valid && parse_phase != PH_HUNT) |->
      (best_slot < frame_block_count && best_area != 32'd0))
    else $error("best block not consistent with frame count");

  // A no-frame result carries no summary
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_NOFRAME) |-> (block_count == 5'd0 && !best_found))
    else $error("no-frame result with summary fields");
`endif

endmodule

>>> tb/obfd_tb_pkg.sv
// Scoreboard for the sync-word block deframer testbench.
// Holds the report type, a byte-level parser of the link stream and the report checker.
// Depends on obfd_pkg.
package obfd_tb_pkg;
  import obfd_pkg::*;

  localparam int FRAME_CAP = 30;

  // One report as it leaves the block, fields in port order
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sig;
    logic [15:0] xp;
    logic [15:0] yp;
    logic [15:0] wd;
    logic [15:0] ht;
    logic [15:0] ang;
    logic        ck_ok;
    logic        cc;
    logic [4:0]  count;
    logic        found;
    logic [4:0]  index;
  } block_report_t;

  class deframe_scoreboard;
    bit            window_mode;
    logic [1:0]    phase;
    bit            odd_half;
    logic [7:0]    lo_hold;
    logic [15:0]   prev_word;
    logic [2:0]    field_cnt;
    logic [15:0]   fields [0:4];
    logic [15:0]   csum_rx;
    logic [15:0]   sum_acc;
    int unsigned   blk_cnt;
    bit            cc_mode;
    logic [31:0]   best_area;
    int unsigned   best_slot;
    bit            best_valid;
    bit            drop_pending;
    block_report_t pending_reports[$];
    int unsigned   errors;
    int unsigned   n_blocks;
    int unsigned   n_summaries;
    int unsigned   n_noframes;

    function new();
      phase = PH_HUNT;
      lo_hold = '0;
      prev_word = NO_WORD;
      field_cnt = '0;
      csum_rx = '0;
      sum_acc = '0;
      best_area = '0;
    endfunction

    function bit in_window(int unsigned x, int unsigned y);
      if (window_mode != WIN_UPPER_TRAP)
        return y > HORIZON_Y && x > CLAW_X_MIN && x < CLAW_X_MAX;
      return y < HORIZON_Y && 9 * x + 2 * y > TRAP_LOW && 9 * x < TRAP_HIGH + 2 * y;
    endfunction

    function void open_frame(bit cc);
      cc_mode = cc;
      blk_cnt = 0;
      best_area = '0;
      best_slot = 0;
      best_valid = 1'b0;
      phase = PH_CSUM;
    endfunction

    function void resume_hunt();
      phase = PH_HUNT;
      prev_word = NO_WORD;
    endfunction

    function block_report_t frame_summary();
      block_report_t r;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.count = blk_cnt[4:0];
      r.found = best_valid;
      r.index = best_valid ? best_slot[4:0] : 5'd0;
      return r;
    endfunction

    // Advance the parser by one assembled word, queue any report it yields
    function void parse_word(logic [15:0] w);
      block_report_t r;
      logic [15:0]   ang;
      logic [31:0]   area;
      r = '0;
      ang = '0;
      case (phase)
        PH_HUNT: begin
          if (w == 16'h0000 && prev_word == 16'h0000) begin
            blk_cnt = 0;
            prev_word = NO_WORD;
            r.kind = KIND_NOFRAME;
            pending_reports.push_back(r);
          end else if (w == SYNC_NORMAL && prev_word == SYNC_NORMAL) begin
            open_frame(1'b0);
          end else if (w == SYNC_CC && prev_word == SYNC_CC) begin
            open_frame(1'b1);
          end else begin
            if (w == SYNC_SLIP) drop_pending = 1'b1;
            prev_word = w;
          end
        end
        PH_CSUM: begin
          if (w == SYNC_NORMAL || w == SYNC_CC) begin
            pending_reports.push_back(frame_summary());
            open_frame(w == SYNC_CC);
          end else if (w == 16'h0000) begin
            pending_reports.push_back(frame_summary());
            resume_hunt();
          end else begin
            csum_rx = w;
            sum_acc = '0;
            field_cnt = '0;
            phase = PH_FIELDS;
          end
        end
        PH_FIELDS: begin
          if (field_cnt < 3'd5) fields[field_cnt] = w;
          else ang = w;
          sum_acc = sum_acc + w;
          field_cnt = field_cnt + 3'd1;
          if ((field_cnt == 3'd5 && !cc_mode) || field_cnt >= 3'd6) begin
            r.kind = KIND_BLOCK;
            r.sig = fields[0];
            r.xp = fields[1];
            r.yp = fields[2];
            r.wd = fields[3];
            r.ht = fields[4];
            r.ang = ang;
            r.ck_ok = (sum_acc == csum_rx);
            r.cc = cc_mode;
            area = fields[3] * fields[4];
            // first block wins a tie, zero area never counts
            if (in_window(fields[1], fields[2]) && area > best_area) begin
              best_area = area;
              best_slot = blk_cnt;
              best_valid = 1'b1;
            end
            if (blk_cnt < 32'hffff) blk_cnt++;
            phase = PH_AFTER;
            pending_reports.push_back(r);
          end
        end
        default: begin
          if (w == SYNC_NORMAL || w == SYNC_CC) begin
            cc_mode = (w == SYNC_CC);
            if (blk_cnt >= FRAME_CAP) begin
              pending_reports.push_back(frame_summary());
              resume_hunt();
            end else begin
              phase = PH_CSUM;
            end
          end else begin
            pending_reports.push_back(frame_summary());
            resume_hunt();
          end
        end
      endcase
    endfunction

    // Note one accepted byte: drop it, hold it as a low byte, or complete a word
    function void note_byte(logic [7:0] b);
      if (drop_pending) begin
        drop_pending = 1'b0;
        return;
      end
      if (!odd_half) begin
        lo_hold = b;
        odd_half = 1'b1;
        return;
      end
      odd_half = 1'b0;
      parse_word({b, lo_hold});
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Match one report transfer against the oldest expectation
    function void check_report(block_report_t got);
      block_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report of kind %0d with nothing expected", got.kind);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      case (want.kind)
        KIND_BLOCK:   n_blocks++;
        KIND_SUMMARY: n_summaries++;
        default:      n_noframes++;
      endcase
      compare_field("result_kind", want.kind, got.kind);
      compare_field("signature", want.sig, got.sig);
      compare_field("x_pos", want.xp, got.xp);
      compare_field("y_pos", want.yp, got.yp);
      compare_field("box_width", want.wd, got.wd);
      compare_field("box_height", want.ht, got.ht);
      compare_field("angle", want.ang, got.ang);
      compare_field("checksum_ok", want.ck_ok, got.ck_ok);
      compare_field("color_code", want.cc, got.cc);
      compare_field("block_count", want.count, got.count);
      compare_field("best_found", want.found, got.found);
      compare_field("best_index", want.index, got.index);
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Testbench top for the sync-word block deframer.
// Streams framed and noisy bytes under both window settings and checks every report.
// Depends on obfd_pkg, obfd_tb_pkg and object_block_frame_deframer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import obfd_pkg::*;
  import obfd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        cfg_ready;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [15:0] signature;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [15:0] angle;
  logic        checksum_ok;
  logic        color_code;
  logic [4:0]  block_count;
  logic        best_found;
  logic [4:0]  best_index;

  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit          steady = 1'b0;
  deframe_scoreboard sb = new();

  object_block_frame_deframer #(.MAX_BLOCKS(FRAME_CAP)) uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Check each report transfer, stall at random outside the steady stretch
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_report(block_report_t'({result_kind, signature, x_pos, y_pos, box_width,
                                       box_height, angle, checksum_ok, color_code,
                                       block_count, best_found, best_index}));
    out_stall <= !steady && $urandom_range(99) < 13;
  end

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  // Hold the input until every expected report is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input bit mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.window_mode = mode;
  endtask

  // Send a checksum word and the record words; length follows the current frame type
  task automatic send_record(input logic [5:0][15:0] f, input bit good_sum);
    logic [15:0] sum;
    int n;
    n = sb.cc_mode ? 6 : 5;
    sum = '0;
    for (int i = 0; i < n; i++) sum += f[i];
    send_word(good_sum ? sum : 16'($urandom));
    for (int i = 0; i < n; i++) send_word(f[i]);
  endtask

  function automatic logic [15:0] rand_extent();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1, 2:    return 16'($urandom_range(200));
      default: return 16'($urandom);
    endcase
  endfunction

  // One well-formed frame with random content and a random way of ending it
  task automatic send_frame(input int nblk);
    logic [15:0] sync;
    logic [5:0][15:0] f;
    // realign to a word boundary first
    while (sb.odd_half || sb.drop_pending) send_byte(8'($urandom));
    sync = $urandom_range(1) ? SYNC_CC : SYNC_NORMAL;
    send_word(sync);
    send_word(sync);
    for (int i = 0; i < nblk; i++) begin
      if (i > 0) begin
        if ($urandom_range(4) == 0) sync = (sync == SYNC_CC) ? SYNC_NORMAL : SYNC_CC;
        send_word(sync);
      end
      f[0] = 16'($urandom);
      case ($urandom_range(7))
        0:       f[1] = 16'($urandom);
        1:       f[1] = 16'(89 + $urandom_range(2));
        2:       f[1] = 16'(99 + $urandom_range(2));
        3:       f[1] = 16'(249 + $urandom_range(2));
        4:       f[1] = 16'(259 + $urandom_range(2));
        default: f[1] = 16'($urandom_range(300));
      endcase
      case ($urandom_range(5))
        0:       f[2] = 16'($urandom);
        1:       f[2] = 16'(109 + $urandom_range(2));
        default: f[2] = 16'($urandom_range(220));
      endcase
      f[3] = rand_extent();
      f[4] = rand_extent();
      f[5] = 16'($urandom);
      send_record(f, $urandom_range(3) != 0);
    end
    // close the frame
    if (nblk == FRAME_CAP) begin
      send_word(sync);
    end else begin
      case ($urandom_range(2))
        0: begin
          if (nblk > 0) send_word(sync);
          send_word(16'h0000);
        end
        1: send_word(nblk > 0 ? 16'($urandom_range(16'haa54)) : 16'h0000);
        default: begin
          if (nblk > 0) send_word(sync);
          send_word(sync == SYNC_CC ? SYNC_NORMAL : SYNC_CC);
        end
      endcase
    end
  endtask

  // Slips, double zeros, lone sync words and stray bytes
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(5))
        0: send_word(SYNC_SLIP);
        1: begin
          send_word(16'h0000);
          send_word(16'h0000);
        end
        2: send_byte(8'hff);
        3: send_word($urandom_range(1) ? SYNC_CC : SYNC_NORMAL);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [5:0][15:0] f;
    int nblk;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_window(WIN_UPPER_TRAP);

    // Directed: double zero, slip with dropped byte, one extreme block, frame closed by a zero word
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(SYNC_SLIP);
    send_byte(8'hff);
    send_word(SYNC_NORMAL);
    send_word(SYNC_NORMAL);
    f = '0;
    f[0] = 16'hffff;
    f[1] = 16'd120;
    f[2] = 16'd50;
    f[3] = 16'hffff;
    f[4] = 16'hffff;
    send_record(f, 1'b1);
    send_word(16'h0000);

    // Random phases, each under its own window setting
    for (int p = 0; p < 4; p++) begin
      write_window(p == 3 ? 1'($urandom_range(1)) : (p % 2 == 0));
      steady = (p == 2);
      if (p == 0) send_frame(FRAME_CAP);
      while (bytes_sent < 25 + (p + 1) * BYTE_TARGET / 4) begin
        if ($urandom_range(9) < 7) begin
          case ($urandom_range(19))
            0:       nblk = FRAME_CAP;
            1:       nblk = FRAME_CAP - 1;
            default: nblk = $urandom_range(5);
          endcase
          send_frame(nblk);
        end else begin
          send_noise();
        end
      end
      steady = 1'b0;
    end
    drain();

    $display("tb_top: %0d bytes sent, %0d reports checked (%0d blocks, %0d frame ends, %0d no-frame)",
             bytes_sent, sb.n_blocks + sb.n_summaries + sb.n_noframes,
             sb.n_blocks, sb.n_summaries, sb.n_noframes);
    $display("tb_top: both window shapes, slips, resyncs and full %0d-block frames covered",
             FRAME_CAP);
    if (sb.errors == 0 && sb.pending_reports.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("timeout after %0d cycles, %0d reports outstanding", cycle_count,
           sb.pending_reports.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
